FILE: rtl/ddws_pkg.sv
package ddws_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [2:0] RegGainP     = 3'd0;
  localparam logic [2:0] RegGainD     = 3'd1;
  localparam logic [2:0] RegGainPrev  = 3'd2;
  localparam logic [2:0] RegGainCorr  = 3'd3;
  localparam logic [2:0] RegAccel     = 3'd4;
  localparam logic [2:0] RegRadius    = 3'd5;
  localparam logic [2:0] RegWheelBase = 3'd6;
  localparam logic [2:0] RegMaxPwm    = 3'd7;

  localparam logic [1:0] ReqTick   = 2'd0;
  localparam logic [1:0] ReqSet    = 2'd1;
  localparam logic [1:0] ReqStop   = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam logic signed [15:0] RadiusSpinLeft  = -16'sd32768;
  localparam logic signed [15:0] RadiusSpinRight = -16'sd32767;

  localparam logic signed [15:0] PowOne = 16'sd16384;

  typedef struct packed {
    logic              start;
    logic              idle;
    logic signed [47:0] corr;
  } lane_ctl_t;

endpackage

FILE: rtl/ddws_if.sv
interface ddws_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic signed [15:0] speed_left_meas;
  logic signed [15:0] speed_right_meas;
  logic signed [15:0] centre_offset;
  logic [14:0] new_speed;
  modport source (output valid, req_type, speed_left_meas, speed_right_meas,
                  centre_offset, new_speed, input ready);
  modport sink   (input valid, req_type, speed_left_meas, speed_right_meas,
                  centre_offset, new_speed, output ready);
endinterface

interface ddws_res_if;
  logic        valid;
  logic        ready;
  logic signed [8:0] duty_left;
  logic signed [8:0] duty_right;
  logic        fwd_left;
  logic        fwd_right;
  modport source (output valid, duty_left, duty_right, fwd_left, fwd_right,
                  input ready);
  modport sink   (input valid, duty_left, duty_right, fwd_left, fwd_right,
                  output ready);
endinterface

interface ddws_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ddws_div.sv
// restoring divider, one quotient bit per cycle, rounds to nearest (ties away)
module ddws_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  output logic              done_o,
  output logic [NumW-1:0]   quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW+1:0] shl;
  logic [DenW+1:0] twice;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shl    = {rem_q, num_q[NumW-1]};
    twice  = '0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        num_d = num_q << 1;
        if (shl >= {2'b00, den_q}) begin
          rem_d = (DenW+1)'(shl - {2'b00, den_q});
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = shl[DenW:0];
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end else begin
        // round: 2*rem >= den bumps the quotient
        twice = {rem_q, 1'b0};
        if (twice >= {2'b00, den_q}) begin
          quo_d = quo_q + 1'b1;
        end
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: rtl/ddws_lane.sv
// one wheel: error, p/d/prev terms accumulated one after another, power update
module ddws_lane #(
  parameter int unsigned TickRateHz = 1024,
  parameter int unsigned FracBits   = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddws_pkg::lane_ctl_t ctl_i,
  input  logic               clear_i,
  input  logic signed [15:0] meas_i,
  input  logic signed [16:0] tgt_i,
  input  logic signed [15:0] gain_p_i,
  input  logic signed [15:0] gain_d_i,
  input  logic signed [15:0] gain_prev_i,
  output logic               done_o,
  output logic signed [15:0] power_o
);
  localparam int unsigned PowShift = FracBits - 6;
  localparam int PowOneL = 16384;

  logic signed [15:0] power_q, power_d;
  logic signed [16:0] prev_q, prev_d;
  logic signed [16:0] err_q, err_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [15:0] mg;
  logic signed [17:0] mv;
  logic signed [33:0] prod_q, prod_d;
  logic [2:0]         ph_q, ph_d;
  logic               done_q, done_d;
  logic signed [17:0] ediff;
  logic signed [17:0] ev;
  logic signed [63:0] mag;
  logic signed [63:0] rnd;
  logic               neg;

  assign ev    = 18'(meas_i) - 18'(tgt_i);
  assign ediff = 18'(err_q) - 18'(prev_q);

  always_comb begin
    mg = gain_p_i;
    mv = 18'(err_q);
    case (ph_q)
      3'd1: begin mg = gain_p_i;    mv = 18'(err_q); end
      3'd2: begin mg = gain_d_i;    mv = ediff;      end
      3'd3: begin mg = gain_prev_i; mv = 18'(prev_q); end
      default: begin mg = gain_p_i; mv = 18'(err_q); end
    endcase
  end

  always_comb begin
    power_d = power_q;
    prev_d  = prev_q;
    err_d   = err_q;
    acc_d   = acc_q;
    ph_d    = ph_q;
    done_d  = 1'b0;
    prod_d  = 34'(mg) * 34'(mv);
    neg     = acc_q[63];
    mag     = neg ? -acc_q : acc_q;
    rnd     = (mag + 64'(1 << PowShift) / 2) >>> PowShift;
    if (clear_i) begin
      power_d = '0;
    end else if (ctl_i.start) begin
      if (ctl_i.idle) begin
        power_d = '0;
        done_d  = 1'b1;
      end else begin
        err_d = ev[16:0];
        acc_d = (64'(power_q) <<< PowShift) + 64'(ctl_i.corr);
        ph_d  = 3'd1;
      end
    end else begin
      case (ph_q)
        3'd2: acc_d = acc_q + 64'(prod_q);
        // d term is scaled by the tick rate
        3'd3: acc_d = acc_q + 64'(51'(prod_q) * $signed(51'(TickRateHz)));
        3'd4: begin
          acc_d = acc_q + 64'(prod_q);
        end
        3'd5: begin
          if (neg) rnd = -rnd;
          if (rnd > 64'(PowOneL)) power_d = ddws_pkg::PowOne;
          else if (rnd < -64'(PowOneL)) power_d = -ddws_pkg::PowOne;
          else power_d = rnd[15:0];
          prev_d = err_q;
          done_d = 1'b1;
        end
        default: ;
      endcase
      if (ph_q != 3'd0) ph_d = (ph_q == 3'd5) ? 3'd0 : ph_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= '0;
      prev_q  <= '0;
      ph_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      power_q <= power_d;
      prev_q  <= prev_d;
      ph_q    <= ph_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o  = done_q;
  assign power_o = power_q;
endmodule

FILE: rtl/ddws_merge.sv
// scales both lane powers to pwm and registers the result
module ddws_merge (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic signed [15:0] pl_i,
  input  logic signed [15:0] pr_i,
  input  logic [7:0]         max_pwm_i,
  output logic signed [8:0]  pwm_l_o,
  output logic signed [8:0]  pwm_r_o,
  output logic               fwd_l_o,
  output logic               fwd_r_o
);
  logic signed [8:0] pl_d, pr_d, pl_q, pr_q;
  logic fl_q, fr_q;

  function automatic logic signed [8:0] scale(logic signed [15:0] p, logic [7:0] m);
    logic signed [24:0] pr;
    logic        [24:0] mag;
    logic        [24:0] q;
    pr  = 25'(p) * 25'($signed({1'b0, m}));
    mag = pr[24] ? 25'(-pr) : 25'(pr);
    q   = mag >> 14;
    return pr[24] ? -9'(q) : 9'(q);
  endfunction

  assign pl_d = scale(pl_i, max_pwm_i);
  assign pr_d = scale(pr_i, max_pwm_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pl_q <= pl_d;
      pr_q <= pr_d;
      fl_q <= (pl_i > 16'sd0);
      fr_q <= (pr_i > 16'sd0);
    end
  end

  assign pwm_l_o = pl_q;
  assign pwm_r_o = pr_q;
  assign fwd_l_o = fl_q;
  assign fwd_r_o = fr_q;
endmodule

FILE: rtl/diff_drive_wheel_speed_pid.sv
// differential-drive wheel speed controller. one request in, one result out.
// a set, stop or unused request, or a tick on an idle target, goes straight
// to the output state; other ticks pass the ramp and split states, an arc tick
// then the serial divider for the arc offset (one quotient bit a cycle for 32
// bits, then a rounding step), and then the two wheel lanes, each forming its
// p, d and previous-error products through one multiplier per lane and folding
// them in one after another. the ramp step is a combinational reciprocal
// multiply. one request is in flight at a time; the next is taken the cycle
// after the result is loaded into the output register, later while an earlier
// result still waits there.
// configuration writes are accepted at any time and must only occur idle.
module diff_drive_wheel_speed_pid #(
  parameter int unsigned TICK_RATE_HZ    = 1024,
  parameter int unsigned SPEED_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddws_req_if.sink    req_i,
  ddws_res_if.source  res_o,
  ddws_cfg_if.sink    cfg_i
);
  localparam int unsigned DivW  = 32;
  // reciprocal for the ramp step, exact for numerators below 2^17
  localparam int unsigned RampS = 17 + $clog2(TICK_RATE_HZ);
  localparam logic [19:0] RampR =
    20'(((64'd1 << RampS) + 64'(TICK_RATE_HZ) - 64'd1) / 64'(TICK_RATE_HZ));
  // radius from 1.0 up is a straight run
  localparam logic signed [15:0] StraightMin = 16'(1 << SPEED_FRAC_BITS);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRamp  = 4'd1;
  localparam logic [3:0] StSplit = 4'd2;
  localparam logic [3:0] StArc   = 4'd3;
  localparam logic [3:0] StLane  = 4'd4;
  localparam logic [3:0] StOut   = 4'd5;
  localparam logic [3:0] StHold  = 4'd6;

  // configuration
  logic signed [15:0] gain_p_q, gain_d_q, gain_prev_q, gain_corr_q, accel_q, radius_q;
  logic [14:0] wbase_q;
  logic [7:0]  max_pwm_q;
  logic        halted_q, halted_d;
  logic [14:0] target_q, target_d;

  logic [3:0] st_q, st_d;
  logic signed [15:0] ml_q, mr_q, co_q;
  logic signed [16:0] tl_q, tl_d, tr_q, tr_d;
  logic signed [47:0] corr_q, corr_d;
  logic               neg_q, neg_d;
  logic               ldone_q, ldone_d, rdone_q, rdone_d;

  logic               div_start;
  logic [DivW-1:0]    div_num;
  logic [16:0]        div_den;
  logic               div_done;
  logic [DivW-1:0]    div_quo;

  ddws_pkg::lane_ctl_t ctl;
  logic               lane_clear;
  logic               done_l, done_r;
  logic signed [15:0] pow_l, pow_r;
  logic               out_load;
  logic               res_valid_q, res_valid_d;

  logic signed [15:0] acc_eff;
  logic signed [17:0] tsum;
  logic signed [33:0] off_s;
  logic signed [34:0] tls, trs;
  logic [29:0]        prod_tw;
  logic [15:0]        amag;
  logic [16:0]        ramp_num;
  logic [39:0]        ramp_prod;
  logic [16:0]        ramp_step;

  assign acc_eff = halted_q ? 16'sd0 : accel_q;
  assign amag    = acc_eff[15] ? 16'(-acc_eff) : 16'(acc_eff);
  assign prod_tw = 30'(target_q) * 30'(wbase_q);

  // ramp step magnitude, rounded to nearest
  assign ramp_num  = 17'(amag) + 17'(TICK_RATE_HZ / 2);
  assign ramp_prod = 40'(ramp_num) * 40'(RampR);
  assign ramp_step = 17'(ramp_prod >> RampS);

  // config port
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0; gain_d_q <= '0; gain_prev_q <= '0; gain_corr_q <= '0;
      accel_q <= '0; radius_q <= 16'sd32767; wbase_q <= '0; max_pwm_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ddws_pkg::RegGainP:     gain_p_q    <= cfg_i.data;
        ddws_pkg::RegGainD:     gain_d_q    <= cfg_i.data;
        ddws_pkg::RegGainPrev:  gain_prev_q <= cfg_i.data;
        ddws_pkg::RegGainCorr:  gain_corr_q <= cfg_i.data;
        ddws_pkg::RegAccel:     accel_q     <= cfg_i.data;
        ddws_pkg::RegRadius:    radius_q    <= cfg_i.data;
        ddws_pkg::RegWheelBase: wbase_q     <= cfg_i.data[14:0];
        ddws_pkg::RegMaxPwm:    max_pwm_q   <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = (st_q == StIdle);

  always_comb begin
    st_d = st_q; target_d = target_q; halted_d = halted_q;
    tl_d = tl_q; tr_d = tr_q; corr_d = corr_q; neg_d = neg_q;
    ldone_d = ldone_q; rdone_d = rdone_q;
    div_start = 1'b0; div_num = '0; div_den = '0;
    ctl = '0; lane_clear = 1'b0; out_load = 1'b0;
    res_valid_d = res_valid_q;
    tsum = '0; off_s = '0; tls = '0; trs = '0;
    if (cfg_i.valid && cfg_i.index == ddws_pkg::RegAccel) halted_d = 1'b0;
    if (res_valid_q && res_o.ready) res_valid_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (req_i.valid) begin
          case (req_i.req_type)
            ddws_pkg::ReqTick: begin
              if (target_q == '0 && acc_eff == '0) begin
                ctl.start = 1'b1; ctl.idle = 1'b1;
                st_d = StOut;
              end else begin
                st_d = StRamp;
              end
            end
            ddws_pkg::ReqSet:  begin target_d = req_i.new_speed; st_d = StOut; end
            ddws_pkg::ReqStop: begin
              target_d = '0; halted_d = 1'b1; lane_clear = 1'b1; st_d = StOut;
            end
            default: st_d = StOut;
          endcase
        end
      end
      StRamp: begin
        tsum = 18'(target_q) + (acc_eff[15] ? -18'(ramp_step) : 18'(ramp_step));
        if (tsum < 0) target_d = '0;
        else if (tsum > 18'sd32767) target_d = 15'h7FFF;
        else target_d = tsum[14:0];
        st_d = StSplit;
      end
      StSplit: begin
        corr_d = '0;
        if (radius_q == ddws_pkg::RadiusSpinLeft) begin
          tl_d = -17'(target_q); tr_d = 17'(target_q); st_d = StLane;
        end else if (radius_q == ddws_pkg::RadiusSpinRight) begin
          tl_d = 17'(target_q); tr_d = -17'(target_q); st_d = StLane;
        end else if (radius_q < StraightMin) begin
          if (radius_q == '0) begin
            if (prod_tw == '0) begin
              tl_d = 17'(target_q); tr_d = 17'(target_q);
            end else begin
              tl_d = 17'sd32767; tr_d = -17'sd32768;
            end
            st_d = StLane;
          end else begin
            div_start = 1'b1;
            div_num = DivW'(prod_tw);
            div_den = radius_q[15] ? 17'(-(17'(radius_q) <<< 1)) : 17'(17'(radius_q) <<< 1);
            neg_d = radius_q[15];
            st_d = StArc;
          end
        end else begin
          tl_d = 17'(target_q); tr_d = 17'(target_q);
          corr_d = 48'(gain_corr_q) * 48'(co_q);
          st_d = StLane;
        end
      end
      StArc: begin
        if (div_done) begin
          off_s = neg_q ? -34'(div_quo) : 34'(div_quo);
          tls = 35'(target_q) + 35'(off_s);
          trs = 35'(target_q) - 35'(off_s);
          tl_d = (tls > 35'sd32767) ? 17'sd32767 :
                 (tls < -35'sd32768) ? -17'sd32768 : tls[16:0];
          tr_d = (trs > 35'sd32767) ? 17'sd32767 :
                 (trs < -35'sd32768) ? -17'sd32768 : trs[16:0];
          st_d = StLane;
        end
      end
      StLane: begin
        ctl.start = 1'b1; ctl.corr = corr_q;
        ldone_d = 1'b0; rdone_d = 1'b0;
        st_d = StHold;
      end
      StHold: begin
        if (done_l) ldone_d = 1'b1;
        if (done_r) rdone_d = 1'b1;
        if ((ldone_q || done_l) && (rdone_q || done_r)) st_d = StOut;
      end
      StOut: begin
        if (!res_valid_q || res_o.ready) begin
          out_load = 1'b1; res_valid_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; target_q <= '0; halted_q <= 1'b0;
      res_valid_q <= 1'b0; ldone_q <= 1'b0; rdone_q <= 1'b0;
    end else begin
      st_q <= st_d; target_q <= target_d; halted_q <= halted_d;
      res_valid_q <= res_valid_d; ldone_q <= ldone_d; rdone_q <= rdone_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      ml_q <= req_i.speed_left_meas; mr_q <= req_i.speed_right_meas;
      co_q <= req_i.centre_offset;
    end
    tl_q <= tl_d; tr_q <= tr_d; corr_q <= corr_d; neg_q <= neg_d;
  end

  ddws_div #(.NumW(DivW), .DenW(17)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // right lane sees the mirrored corridor correction
  ddws_pkg::lane_ctl_t ctl_r;
  always_comb begin
    ctl_r = ctl;
    ctl_r.corr = -ctl.corr;
  end

  ddws_lane #(.TickRateHz(TICK_RATE_HZ), .FracBits(SPEED_FRAC_BITS)) u_lane_l (
    .clk_i, .rst_ni, .ctl_i(ctl), .clear_i(lane_clear), .meas_i(ml_q), .tgt_i(tl_q),
    .gain_p_i(gain_p_q), .gain_d_i(gain_d_q), .gain_prev_i(gain_prev_q),
    .done_o(done_l), .power_o(pow_l)
  );

  ddws_lane #(.TickRateHz(TICK_RATE_HZ), .FracBits(SPEED_FRAC_BITS)) u_lane_r (
    .clk_i, .rst_ni, .ctl_i(ctl_r), .clear_i(lane_clear), .meas_i(mr_q), .tgt_i(tr_q),
    .gain_p_i(gain_p_q), .gain_d_i(gain_d_q), .gain_prev_i(gain_prev_q),
    .done_o(done_r), .power_o(pow_r)
  );

  ddws_merge u_merge (
    .clk_i, .load_i(out_load), .pl_i(pow_l), .pr_i(pow_r), .max_pwm_i(max_pwm_q),
    .pwm_l_o(res_o.duty_left), .pwm_r_o(res_o.duty_right),
    .fwd_l_o(res_o.fwd_left), .fwd_r_o(res_o.fwd_right)
  );

  assign res_o.valid = res_valid_q;

  // the block takes no request while one is in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready) else $error("request overlap");
  // a stop leaves both powers at zero
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.req_type == ddws_pkg::ReqStop)
    |=> (pow_l == '0 && pow_r == '0 && halted_q)) else $error("stop did not clear");
  // both lanes finish together
  a_lane_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_l == done_r) else $error("lanes out of step");
endmodule

FILE: sim/tb_ddws_ifs.sv
// the channel interfaces come with the rtl (rtl/ddws_if.sv); this file holds only the
// testbench utility package with its random percentage helper
package tb_ddws_util_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  function automatic int unsigned rand_pct();
    return $urandom_range(99, 0);
  endfunction
endpackage

FILE: sim/tb_diff_drive_wheel_speed_pid.sv
module tb_diff_drive_wheel_speed_pid;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TickHz = 1024;
  localparam longint PowDiv = 64;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ddws_req_if req_if ();
  ddws_res_if res_if ();
  ddws_cfg_if cfg_if ();

  diff_drive_wheel_speed_pid u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  typedef struct {
    logic signed [8:0] pwm_l;
    logic signed [8:0] pwm_r;
    logic              fwd_l;
    logic              fwd_r;
  } wheel_out_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] meas_l;
    logic signed [15:0] meas_r;
    logic signed [15:0] offset;
    logic [14:0]        speed;
  } drive_req_t;

  // drive controller predictor with its own copy of registers and state
  class drive_scoreboard;
    longint kp, kd, kprev, kcorr, acc_reg, radius, base, pwm_max;
    longint tgt, pow_l, pow_r, err_l_prev, err_r_prev;
    bit     stopped;
    wheel_out_t pending[$];
    int     errors;

    function new();
      kp = 0; kd = 0; kprev = 0; kcorr = 0; acc_reg = 0; radius = 32767;
      base = 0; pwm_max = 0; tgt = 0; pow_l = 0; pow_r = 0;
      err_l_prev = 0; err_r_prev = 0; stopped = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        ddws_pkg::RegGainP:     kp = longint'($signed(d));
        ddws_pkg::RegGainD:     kd = longint'($signed(d));
        ddws_pkg::RegGainPrev:  kprev = longint'($signed(d));
        ddws_pkg::RegGainCorr:  kcorr = longint'($signed(d));
        ddws_pkg::RegAccel: begin
          acc_reg = longint'($signed(d));
          stopped = 0;
        end
        ddws_pkg::RegRadius:    radius = longint'($signed(d));
        ddws_pkg::RegWheelBase: base = longint'(d[14:0]);
        ddws_pkg::RegMaxPwm:    pwm_max = longint'(d[7:0]);
        default: ;
      endcase
    endfunction

    // divide to nearest, ties away from zero
    function longint div_near(longint n, longint d);
      longint m;
      m = (n < 0) ? -n : n;
      m = (m + d / 2) / d;
      return (n < 0) ? -m : m;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint next_power(longint pw, longint corr, longint e, longint pe);
      longint a;
      a = pw * PowDiv + corr + kp * e + kd * (e - pe) * TickHz + kprev * pe;
      return sat(div_near(a, PowDiv), -16384, 16384);
    endfunction

    function void run_tick(longint ml, longint mr, longint co);
      longint a, t, tl, tr, corr, num, den, off, el, er;
      a = stopped ? 0 : acc_reg;
      corr = 0;
      if (tgt == 0 && a == 0) begin
        pow_l = 0;
        pow_r = 0;
        return;
      end
      t = sat(tgt + div_near(a, TickHz), 0, 32767);
      tgt = t;
      if (radius == -32768) begin
        tl = -t; tr = t;
      end else if (radius == -32767) begin
        tl = t; tr = -t;
      end else if (radius < 4096) begin
        num = t * base;
        den = 2 * radius;
        if (den == 0) off = (num == 0) ? 0 : 65536;
        else if (den < 0) off = div_near(-num, -den);
        else off = div_near(num, den);
        tl = sat(t + off, -32768, 32767);
        tr = sat(t - off, -32768, 32767);
      end else begin
        tl = t; tr = t;
        corr = kcorr * co;
      end
      // errors wrap to 32 bits; the rtl keeps 17 bits, enough for these differences
      el = longint'(int'(ml - tl));
      er = longint'(int'(mr - tr));
      pow_l = next_power(pow_l, corr, el, err_l_prev);
      pow_r = next_power(pow_r, -corr, er, err_r_prev);
      err_l_prev = el;
      err_r_prev = er;
    endfunction

    function void note_request(drive_req_t r);
      wheel_out_t w;
      case (r.kind)
        ddws_pkg::ReqTick: run_tick(r.meas_l, r.meas_r, r.offset);
        ddws_pkg::ReqSet:  tgt = longint'(r.speed);
        ddws_pkg::ReqStop: begin
          tgt = 0; stopped = 1; pow_l = 0; pow_r = 0;
        end
        default: ;
      endcase
      w.pwm_l = 9'((pow_l * pwm_max) / 16384);
      w.pwm_r = 9'((pow_r * pwm_max) / 16384);
      w.fwd_l = pow_l > 0;
      w.fwd_r = pow_r > 0;
      pending.push_back(w);
    endfunction

    function void check_result(wheel_out_t got);
      wheel_out_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t unexpected result pwm %0d/%0d", $time, got.pwm_l, got.pwm_r);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.pwm_l !== exp_w.pwm_l) begin
        $display("%0t duty_left exp %0d got %0d", $time, exp_w.pwm_l, got.pwm_l);
        errors++;
      end
      if (got.pwm_r !== exp_w.pwm_r) begin
        $display("%0t duty_right exp %0d got %0d", $time, exp_w.pwm_r, got.pwm_r);
        errors++;
      end
      if (got.fwd_l !== exp_w.fwd_l) begin
        $display("%0t fwd_left exp %0b got %0b", $time, exp_w.fwd_l, got.fwd_l);
        errors++;
      end
      if (got.fwd_r !== exp_w.fwd_r) begin
        $display("%0t fwd_right exp %0b got %0b", $time, exp_w.fwd_r, got.fwd_r);
        errors++;
      end
    endfunction
  endclass

  drive_scoreboard sb;
  int  idle_pct_src = 23;
  int  idle_pct_snk = 23;
  bit  hold_off = 0;
  int  quiet_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // scoreboard hooks at the rising edge
  always @(posedge clk_i) begin
    drive_req_t r;
    wheel_out_t w;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        r.kind = req_if.req_type; r.meas_l = req_if.speed_left_meas;
        r.meas_r = req_if.speed_right_meas; r.offset = req_if.centre_offset;
        r.speed = req_if.new_speed;
        sb.note_request(r);
      end
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (res_if.valid && res_if.ready) begin
        w.pwm_l = res_if.duty_left; w.pwm_r = res_if.duty_right;
        w.fwd_l = res_if.fwd_left; w.fwd_r = res_if.fwd_right;
        sb.check_result(w);
      end
    end
  end

  // result side ready, random stalls plus the long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= !hold_off && (tb_ddws_util_pkg::rand_pct() >= idle_pct_snk);
  end

  // watchdog: cycles without any accepted request, result or configuration write
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // one request, with a random gap before it
  task automatic send_req(drive_req_t r);
    @(negedge clk_i);
    while (tb_ddws_util_pkg::rand_pct() < idle_pct_src) @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.req_type <= r.kind;
    req_if.speed_left_meas <= r.meas_l;
    req_if.speed_right_meas <= r.meas_r;
    req_if.centre_offset <= r.offset;
    req_if.new_speed <= r.speed;
    do @(posedge clk_i); while (!req_if.ready);
    // then lower valid; a later call raises it again
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  // wait until every result is in, then let the block settle before writes
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic drive_req_t rand_req(int tick_pct);
    drive_req_t r;
    int p;
    p = $urandom_range(99, 0);
    if (p < tick_pct) r.kind = ddws_pkg::ReqTick;
    else if (p < tick_pct + 12) r.kind = ddws_pkg::ReqSet;
    else if (p < tick_pct + 15) r.kind = ddws_pkg::ReqStop;
    else r.kind = ddws_pkg::ReqUnused;
    // mostly modest speeds so the loop stays in range, some full-width values
    if ($urandom_range(3, 0) == 0) begin
      r.meas_l = 16'($urandom); r.meas_r = 16'($urandom); r.offset = 16'($urandom);
      r.speed = 15'($urandom);
    end else begin
      r.meas_l = 16'($signed($urandom_range(8000, 0)) - 2000);
      r.meas_r = 16'($signed($urandom_range(8000, 0)) - 2000);
      r.offset = 16'($signed($urandom_range(2000, 0)) - 1000);
      r.speed  = 15'($urandom_range(8000, 0));
    end
    return r;
  endfunction

  function automatic drive_req_t mk(logic [1:0] k, int ml, int mr, int co, int sp);
    drive_req_t r;
    r.kind = k; r.meas_l = 16'(ml); r.meas_r = 16'(mr); r.offset = 16'(co);
    r.speed = 15'(sp);
    return r;
  endfunction

  // one configuration phase: random or extreme register values
  task automatic config_phase(bit extreme);
    logic [2:0] idx;
    logic [15:0] v;
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      if (extreme) v = ($urandom_range(1, 0) != 0) ? 16'h7fff : 16'h8000;
      else if (idx == ddws_pkg::RegMaxPwm) v = 16'($urandom_range(255, 0));
      else if (idx == ddws_pkg::RegWheelBase) v = 16'($urandom_range(8192, 0));
      else if (idx == ddws_pkg::RegRadius) begin
        case ($urandom_range(5, 0))
          0: v = ddws_pkg::RadiusSpinLeft;
          1: v = ddws_pkg::RadiusSpinRight;
          2: v = 16'd0;
          3: v = 16'($urandom_range(4095, 1));
          4: v = 16'(-int'($urandom_range(4095, 1)));
          default: v = 16'($urandom_range(32767, 4096));
        endcase
      end else if (idx == ddws_pkg::RegAccel) begin
        v = 16'($signed($urandom_range(8192, 0)) - 2048);
      end else v = 16'($signed($urandom_range(512, 0)) - 256);
      write_reg(idx, v);
    end
  endtask

  initial begin
    // request and configuration inputs known from time zero
    req_if.valid = 0; req_if.req_type = ddws_pkg::ReqTick; req_if.speed_left_meas = 0;
    req_if.speed_right_meas = 0; req_if.centre_offset = 0; req_if.new_speed = 0;
    cfg_if.valid = 0; cfg_if.index = ddws_pkg::RegGainP; cfg_if.data = 0;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every request, extremes and each special case
    write_reg(ddws_pkg::RegMaxPwm, 16'd255);
    send_req(mk(ddws_pkg::ReqTick, 0, 0, 0, 0));                   // idle tick
    drain();
    write_reg(ddws_pkg::RegGainP, 16'd256);
    write_reg(ddws_pkg::RegGainD, 16'd1);
    write_reg(ddws_pkg::RegGainPrev, 16'hff00);
    write_reg(ddws_pkg::RegGainCorr, 16'd64);
    write_reg(ddws_pkg::RegAccel, 16'd4096);
    send_req(mk(ddws_pkg::ReqSet, 0, 0, 0, 32767));               // top speed
    send_req(mk(ddws_pkg::ReqTick, 32767, -32768, 32767, 0));     // saturated ramp
    send_req(mk(ddws_pkg::ReqTick, -32768, 32767, -32768, 0));
    send_req(mk(ddws_pkg::ReqUnused, 0, 0, 0, 0));                // unused code
    send_req(mk(ddws_pkg::ReqStop, 0, 0, 0, 0));
    send_req(mk(ddws_pkg::ReqTick, 100, 100, 0, 0));              // halted, idle
    send_req(mk(ddws_pkg::ReqSet, 0, 0, 0, 2000));
    send_req(mk(ddws_pkg::ReqTick, 100, -100, 0, 0));             // halted, nonzero target
    drain();
    write_reg(ddws_pkg::RegAccel, 16'h8000);                      // ramp down, most negative acceleration
    write_reg(ddws_pkg::RegRadius, ddws_pkg::RadiusSpinLeft);
    send_req(mk(ddws_pkg::ReqTick, 0, 0, 0, 0));
    send_req(mk(ddws_pkg::ReqTick, 0, 0, 0, 0));
    drain();
    write_reg(ddws_pkg::RegRadius, ddws_pkg::RadiusSpinRight);
    write_reg(ddws_pkg::RegAccel, 16'd1);                         // ramp step rounds to 0
    send_req(mk(ddws_pkg::ReqSet, 0, 0, 0, 500));
    send_req(mk(ddws_pkg::ReqTick, 10, 20, 0, 0));
    drain();
    write_reg(ddws_pkg::RegRadius, 16'd0);                        // zero radius
    write_reg(ddws_pkg::RegWheelBase, 16'h7fff);
    send_req(mk(ddws_pkg::ReqTick, 0, 0, 0, 0));
    drain();
    write_reg(ddws_pkg::RegWheelBase, 16'd0);
    send_req(mk(ddws_pkg::ReqTick, 0, 0, 0, 0));
    drain();
    write_reg(ddws_pkg::RegRadius, 16'hf000);                     // negative arc
    write_reg(ddws_pkg::RegWheelBase, 16'd2048);
    send_req(mk(ddws_pkg::ReqTick, 300, 300, 0, 0));
    send_req(mk(ddws_pkg::ReqTick, 300, 300, 0, 0));
    drain();

    // random phases, settings change between them
    for (int ph = 0; ph < 17; ph++) begin
      config_phase(ph == 3 || ph == 11);
      if (ph == 5) begin
        idle_pct_src = 0; idle_pct_snk = 0;
      end else begin
        idle_pct_src = 23; idle_pct_snk = 23;
      end
      if (ph == 8) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 48; i++) send_req(rand_req(70));
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
